FILE: hdl/ecpr_pkg.sv
// Shared types and constants for the enhanced clock page replacer.
// Used by ecpr_cell and enhanced_clock_page_replacer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ecpr_pkg;

  // Width of the page number fields on the ports.
  localparam int FIELD_BITS = 20;

  // Command codes of an input transfer.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ACCESS = 2'd1,
    CMD_EVICT  = 2'd2
  } cmd_t;

  // Status codes of a result transfer.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Which class of entry an eviction takes, decided from the whole table.
  //   MODE_CLEAN      first entry neither accessed nor dirty.
  //   MODE_DIRTY      first dirty entry not accessed; older entries lose accessed.
  //   MODE_CLEAN_AGED all entries accessed: all cleared, first clean entry taken.
  //   MODE_ANY        all entries accessed and dirty: all cleared, oldest taken.
  typedef enum logic [1:0] {
    MODE_CLEAN      = 2'd0,
    MODE_DIRTY      = 2'd1,
    MODE_CLEAN_AGED = 2'd2,
    MODE_ANY        = 2'd3
  } mode_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic  go;
    cmd_t  cmd;
    logic  wr;
    mode_t mode;
  } ctl_t;

  // Flags that ripple from the oldest cell toward the newest.
  typedef struct packed {
    logic s00;    // an older entry is valid, not accessed, not dirty
    logic s01;    // an older entry is valid, not accessed, dirty
    logic sd0;    // an older entry is valid and clean
    logic sv;     // an older entry is valid
    logic vprev;  // the next older entry is valid (or this is the first cell)
    logic hit;    // an older entry matched the accessed page
  } chain_t;

  // Flag bits of one entry, handed to the next older cell on removal.
  typedef struct packed {
    logic acc;
    logic dirty;
    logic valid;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/ecpr_cell.sv
// One table slot of the enhanced clock page replacer.
// Depends on ecpr_pkg; instantiated in a row by enhanced_clock_page_replacer.
`timescale 1ns / 1ps
`default_nettype none

module ecpr_cell #(
  parameter int PAGE_BITS = 20
) (
  input  wire                   clk,
  input  wire                   rst,
  input  ecpr_pkg::ctl_t        ctl,
  input  wire  [PAGE_BITS-1:0]  cmd_page,
  // Priority chain from the older neighbor and on to the newer one.
  input  ecpr_pkg::chain_t      chain_in,
  output ecpr_pkg::chain_t      chain_out,
  input  wire  [PAGE_BITS-1:0]  victim_in,
  output logic [PAGE_BITS-1:0]  victim_out,
  // Contents of the newer neighbor, taken when the table compacts.
  input  ecpr_pkg::entry_t      nbr_entry,
  input  wire  [PAGE_BITS-1:0]  nbr_page,
  output ecpr_pkg::entry_t      own_entry,
  output logic [PAGE_BITS-1:0]  own_page
);

  logic [PAGE_BITS-1:0] page;
  logic                 acc;
  logic                 dirty;
  logic                 valid;

  logic f00;
  logic f01;
  logic fd0;
  logic match;
  logic seen_before;
  logic mine;
  logic sel;
  logic shift;

  // Class flags of this entry and the hit compare.
  assign f00   = valid & ~acc & ~dirty;
  assign f01   = valid & ~acc & dirty;
  assign fd0   = valid & ~dirty;
  assign match = valid && (page == cmd_page);

  // Hand the accumulated flags on to the newer neighbor.
  always_comb begin
    chain_out.s00   = chain_in.s00 | f00;
    chain_out.s01   = chain_in.s01 | f01;
    chain_out.sd0   = chain_in.sd0 | fd0;
    chain_out.sv    = chain_in.sv | valid;
    chain_out.vprev = valid;
    chain_out.hit   = chain_in.hit | match;
  end

  // Pick the class that the eviction takes and see whether this entry is the first.
  always_comb begin
    case (ctl.mode)
      ecpr_pkg::MODE_CLEAN: begin
        seen_before = chain_in.s00;
        mine        = f00;
      end
      ecpr_pkg::MODE_DIRTY: begin
        seen_before = chain_in.s01;
        mine        = f01;
      end
      ecpr_pkg::MODE_CLEAN_AGED: begin
        seen_before = chain_in.sd0;
        mine        = fd0;
      end
      default: begin
        // The oldest valid entry: only the first cell has no valid entry before it.
        seen_before = chain_in.sv;
        mine        = valid;
      end
    endcase
    sel   = mine & ~seen_before;
    shift = seen_before | mine;
  end

  // The chosen entry puts its page on the victim chain.
  assign victim_out = victim_in | (sel ? page : '0);

  assign own_entry.acc   = acc;
  assign own_entry.dirty = dirty;
  assign own_entry.valid = valid;
  assign own_page        = page;

  // Flag bits of the entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 1'b0;
      dirty <= 1'b0;
      valid <= 1'b0;
    end else if (ctl.go) begin
      case (ctl.cmd)
        ecpr_pkg::CMD_INSERT: begin
          if (!valid && chain_in.vprev) begin
            acc   <= 1'b0;
            dirty <= 1'b0;
            valid <= 1'b1;
          end
        end
        ecpr_pkg::CMD_ACCESS: begin
          if (match) begin
            acc <= 1'b1;
            if (ctl.wr) begin
              dirty <= 1'b1;
            end
          end
        end
        ecpr_pkg::CMD_EVICT: begin
          if (shift) begin
            // Entries from the victim on take the contents of the newer neighbor.
            acc   <= (ctl.mode == ecpr_pkg::MODE_CLEAN ||
                      ctl.mode == ecpr_pkg::MODE_DIRTY) ? nbr_entry.acc : 1'b0;
            dirty <= nbr_entry.dirty;
            valid <= nbr_entry.valid;
          end else if (ctl.mode != ecpr_pkg::MODE_CLEAN) begin
            // The scan passed over this entry and took away its second chance.
            acc <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Page number of the entry.
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      if (ctl.cmd == ecpr_pkg::CMD_INSERT && !valid && chain_in.vprev) begin
        page <= cmd_page;
      end else if (ctl.cmd == ecpr_pkg::CMD_EVICT && shift) begin
        page <= nbr_page;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/enhanced_clock_page_replacer.sv
// Top level of the enhanced clock page replacer: controller and row of table cells.
// Depends on ecpr_pkg and ecpr_cell.
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low; that cycle
// registers it, and in the next one the row of FRAMES cells resolves the
// lookup or the victim scan through its neighbor chain and updates the table.
// busy is high during that cycle only, and done strobes the result
// in the cycle after it, the same cycle in which the next command may be
// taken; start is ignored while busy is high. The receiver cannot
// stall: a result is on victim_page and status for the single cycle that
// done is high and is not repeated. The table starts empty after reset.
module enhanced_clock_page_replacer #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 20
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  command,
  input  wire  [19:0] page_number,
  input  wire         is_write,
  output logic        done,
  output logic [19:0] victim_page,
  output logic [1:0]  status
);

  localparam int FB = ecpr_pkg::FIELD_BITS;

  ecpr_pkg::state_t state;
  ecpr_pkg::state_t state_next;

  ecpr_pkg::cmd_t       cmd_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 wr_q;

  ecpr_pkg::ctl_t     ctl;
  ecpr_pkg::mode_t    mode;
  ecpr_pkg::status_t  status_next;
  logic               full;
  logic               empty;
  logic [FRAMES-1:0]  valid_vec;

  ecpr_pkg::chain_t     chain    [FRAMES+1];
  logic [PAGE_BITS-1:0] vic      [FRAMES+1];
  ecpr_pkg::entry_t     ent      [FRAMES+1];
  logic [PAGE_BITS-1:0] ent_page [FRAMES+1];

  // Controller state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecpr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: start moves S_IDLE to S_EXEC, and S_EXEC always returns to S_IDLE.
  always_comb begin
    state_next = state;
    case (state)
      ecpr_pkg::S_IDLE: begin
        if (start) begin
          state_next = ecpr_pkg::S_EXEC;
        end
      end
      ecpr_pkg::S_EXEC: begin
        state_next = ecpr_pkg::S_IDLE;
      end
      default: begin
        state_next = ecpr_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state == ecpr_pkg::S_EXEC);

  // Capture the command at the input transfer.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q  <= ecpr_pkg::cmd_t'(command);
      page_q <= PAGE_BITS'(page_number);
      wr_q   <= is_write;
    end
  end

  // Chain ends: the newest cell's flags cover the whole table.
  assign chain[0] = '{s00: 1'b0, s01: 1'b0, sd0: 1'b0, sv: 1'b0, vprev: 1'b1, hit: 1'b0};
  assign vic[0]   = '0;
  assign ent[FRAMES]      = '0;
  assign ent_page[FRAMES] = '0;

  assign full  = chain[FRAMES].vprev;
  assign empty = ~ent[0].valid;

  // Eviction class, from which classes exist anywhere in the table.
  always_comb begin
    if (chain[FRAMES].s00) begin
      mode = ecpr_pkg::MODE_CLEAN;
    end else if (chain[FRAMES].s01) begin
      mode = ecpr_pkg::MODE_DIRTY;
    end else if (chain[FRAMES].sd0) begin
      mode = ecpr_pkg::MODE_CLEAN_AGED;
    end else begin
      mode = ecpr_pkg::MODE_ANY;
    end
  end

  assign ctl.go   = busy;
  assign ctl.cmd  = cmd_q;
  assign ctl.wr   = wr_q;
  assign ctl.mode = mode;

  // Row of table cells, oldest entry in cell 0.
  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    ecpr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cmd_page   (page_q),
      .chain_in   (chain[k]),
      .chain_out  (chain[k+1]),
      .victim_in  (vic[k]),
      .victim_out (vic[k+1]),
      .nbr_entry  (ent[k+1]),
      .nbr_page   (ent_page[k+1]),
      .own_entry  (ent[k]),
      .own_page   (ent_page[k])
    );
    assign valid_vec[k] = ent[k].valid;
  end

  // Result status of the command in the cell row.
  always_comb begin
    case (cmd_q)
      ecpr_pkg::CMD_INSERT: status_next = full ? ecpr_pkg::ST_FULL : ecpr_pkg::ST_OK;
      ecpr_pkg::CMD_ACCESS: begin
        status_next = chain[FRAMES].hit ? ecpr_pkg::ST_OK : ecpr_pkg::ST_MISSING;
      end
      ecpr_pkg::CMD_EVICT:  status_next = empty ? ecpr_pkg::ST_EMPTY : ecpr_pkg::ST_OK;
      default:              status_next = ecpr_pkg::ST_OK;
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (busy) begin
      status <= status_next;
      if (cmd_q == ecpr_pkg::CMD_EVICT && !empty) begin
        victim_page <= FB'(vic[FRAMES]);
      end else begin
        victim_page <= '0;
      end
    end
  end

  // busy is always low in the cycle after it was high.
  a_exec_one_cycle : assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("cell row held a command for more than one cycle");

  // Every input transfer leads to busy and then to a done strobe.
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy ##1 done)
    else $error("input transfer did not produce a result");

  // No result without a command in the row just before it.
  a_done_from_exec : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command");

  // Valid entries always form a prefix of the row.
  a_valid_prefix : assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid entries are not contiguous from the oldest cell");

endmodule

`default_nettype wire
